### hw/rtl/hfm_pkg.sv
// Package for the multiscale hole-fill max map: sizes, level geometry,
// codes and shared types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hfm_pkg;

  localparam int unsigned ROWS_MAX = 256;
  localparam int unsigned COLS_MAX = 256;
  localparam int unsigned LEVELS   = 4;

  localparam int unsigned RELIEF_W = 16;
  localparam int unsigned ENTRY_W  = RELIEF_W + 1;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned USE_W    = 4;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RELIEF_W-1:0] EMPTY_RELIEF = 16'hFF00;

  localparam logic [CFG_W-1:0] MAP_ROWS_RST = 9'd256;
  localparam logic [CFG_W-1:0] MAP_COLS_RST = 9'd256;
  localparam logic [2:0]       LEVELS_RST   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS   = 2'd2;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic {
    SWEEP_IDLE = 1'b0,
    SWEEP_RUN  = 1'b1
  } sweep_state_e;

  function automatic int unsigned lvl_dim(int unsigned n, int unsigned d);
    return (n + (32'd1 << d) - 32'd1) >> d;
  endfunction

  function automatic int unsigned lvl_w(int unsigned d);
    return lvl_dim(COLS_MAX, d);
  endfunction

  function automatic int unsigned lvl_depth(int unsigned d);
    return lvl_dim(ROWS_MAX, d) * lvl_w(d);
  endfunction

  function automatic int unsigned lvl_aw(int unsigned d);
    return (lvl_depth(d) > 1) ? $clog2(lvl_depth(d)) : 1;
  endfunction

  function automatic logic [31:0] lvl_addr(int unsigned d, logic [7:0] row, logic [7:0] col);
    logic [31:0] r;
    logic [31:0] c;
    r = 32'(row) >> d;
    c = 32'(col) >> d;
    return r * lvl_w(d) + c;
  endfunction

  localparam int unsigned SWEEP_AW = lvl_aw(0);
  localparam logic [SWEEP_AW-1:0] SWEEP_LAST = SWEEP_AW'(lvl_depth(0) - 1);

  typedef struct packed {
    logic                busy;
    logic [SWEEP_AW-1:0] addr;
  } sweep_t;

endpackage

`default_nettype wire

### hw/rtl/hfm_if.sv
// Stream interfaces for the item and result channels of the hole-fill max map.
// Each carries valid, ready and the payload fields; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hfm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        cell_row;
  logic [7:0]        cell_col;
  logic signed [15:0] point_relief;

  modport source (output valid, kind, cell_row, cell_col, point_relief, input ready);
  modport sink   (input valid, kind, cell_row, cell_col, point_relief, output ready);
endinterface

interface hfm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_relief;
  logic               found;
  logic [1:0]         level_used;
  logic               out_of_map;

  modport source (output valid, cell_relief, found, level_used, out_of_map, input ready);
  modport sink   (input valid, cell_relief, found, level_used, out_of_map, output ready);
endinterface

`default_nettype wire

### hw/rtl/hfm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Read data holds while no read is issued. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hfm_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/hfm_sweep.sv
// Clearing sequencer: walks every address of the level memories once after
// reset and after each clear item. Depends on hfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfm_sweep
  import hfm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output      sweep_t sweep_o
);

  sweep_state_e        state_q, state_d;
  logic [SWEEP_AW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SWEEP_RUN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      SWEEP_IDLE: begin
        if (start_i) begin
          state_d = SWEEP_RUN;
          cnt_d   = '0;
        end
      end
      SWEEP_RUN: begin
        if (cnt_q == SWEEP_LAST) begin
          state_d = SWEEP_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = SWEEP_IDLE;
      end
    endcase
  end

  assign sweep_o.busy = (state_q == SWEEP_RUN);
  assign sweep_o.addr = cnt_q;

endmodule

`default_nettype wire

### hw/rtl/multiscale_hole_fill_max_map.sv
// Top level of the multiscale hole-fill max map: one RAM per pyramid level,
// read-modify-write with forwarding. Depends on hfm_pkg, hfm_if, hfm_ram, hfm_sweep.
//
// Usage. Items arrive on in_i (kind, cell_row, cell_col, point_relief) and are
// taken by a valid/ready transfer. Add and query items each give one result on
// out_o; clear items and unknown kinds give none. Configuration is written
// through cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle.
// Data path: an accepted item reads all level memories in parallel into the
// stage-1 registers; when the output register is free, the update is written back
// and the result is loaded into the output register.
// Throughput: one add or query per cycle while out_o.ready stays high and no clear
// is running, set by the single read-modify-write per level memory; a write followed
// at once by a read of the same entry is served from a forwarding register.
// Reset and clear: the block walks all lvl_depth(0) addresses of the level memories
// (65536 at the default sizes), one address per cycle in every level at once;
// in_i.ready stays low meanwhile, configuration writes are still taken.
// Stall: a result waits in the output register while out_o.ready is low; one
// further item can be accepted and is held after its read until the result
// register frees.
`timescale 1ns / 1ps
`default_nettype none

module multiscale_hole_fill_max_map
  import hfm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  hfm_in_if.sink                    in_i,
  hfm_out_if.source                 out_o
);

  logic [CFG_W-1:0] map_rows_q;
  logic [CFG_W-1:0] map_cols_q;
  logic [2:0]       levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q <= MAP_ROWS_RST;
      map_cols_q <= MAP_COLS_RST;
      levels_q   <= LEVELS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_ROWS: map_rows_q <= cfg_data_i;
        CFG_MAP_COLS: map_cols_q <= cfg_data_i;
        CFG_LEVELS:   levels_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  sweep_t sweep;
  logic   sweep_start;

  hfm_sweep u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sweep_start),
    .sweep_o (sweep)
  );

  logic                accept;
  logic                in_ready;
  logic                exec;
  logic                out_free;
  logic                s1_result;
  logic                outside_d;
  logic                inrange_d;

  logic                s1_valid_q;
  logic [1:0]          s1_kind_q;
  logic [RELIEF_W-1:0] s1_relief_q;
  logic                s1_outside_q;
  logic                s1_inrange_q;

  logic                out_valid_q;
  logic [RELIEF_W-1:0] cell_relief_q;
  logic                found_q;
  logic [LEVEL_W-1:0]  level_used_q;
  logic                out_of_map_q;

  logic [ENTRY_W-1:0]  entries [LEVELS];

  assign accept    = in_i.valid && in_ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_result = (s1_kind_q == KIND_ADD) || (s1_kind_q == KIND_QUERY);
  assign exec      = s1_valid_q && (out_free || !s1_result);
  assign in_ready  = !sweep.busy && !(s1_valid_q && (s1_kind_q == KIND_CLEAR)) &&
                     (!s1_valid_q || exec);
  assign sweep_start = exec && (s1_kind_q == KIND_CLEAR);
  assign in_i.ready  = in_ready;

  assign inrange_d = (32'(in_i.cell_row) < ROWS_MAX) && (32'(in_i.cell_col) < COLS_MAX);
  assign outside_d = ({1'b0, in_i.cell_row} >= map_rows_q) ||
                     ({1'b0, in_i.cell_col} >= map_cols_q) || !inrange_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (exec) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q    <= in_i.kind;
      s1_relief_q  <= in_i.point_relief;
      s1_outside_q <= outside_d;
      s1_inrange_q <= inrange_d;
    end
  end

  for (genvar d = 0; d < LEVELS; d++) begin : g_level
    localparam int unsigned DEPTH = lvl_depth(d);
    localparam int unsigned AW    = lvl_aw(d);

    logic [31:0]        raddr_full;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      s1_addr_q;
    logic               we;
    logic               upd;
    logic               sweep_hit;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] entry;
    logic               fwd_hit_q;
    logic [ENTRY_W-1:0] fwd_data_q;

    assign raddr_full = lvl_addr(d, in_i.cell_row, in_i.cell_col);
    assign raddr      = raddr_full[AW-1:0];
    assign entry      = fwd_hit_q ? fwd_data_q : rdata;
    assign entries[d] = entry;

    assign upd = exec && (s1_kind_q == KIND_ADD) && !s1_outside_q &&
                 (!entry[ENTRY_W-1] ||
                  ($signed(s1_relief_q) > $signed(entry[RELIEF_W-1:0])));
    assign sweep_hit = sweep.busy && (32'(sweep.addr) < DEPTH);
    assign we    = sweep_hit || upd;
    assign waddr = sweep.busy ? sweep.addr[AW-1:0] : s1_addr_q;
    assign wdata = sweep.busy ? '0 : {1'b1, s1_relief_q};

    always_ff @(posedge clk_i) begin
      if (accept) begin
        s1_addr_q  <= raddr;
        fwd_hit_q  <= we && (waddr == raddr);
        fwd_data_q <= wdata;
      end
    end

    hfm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (accept),
      .raddr_i (raddr),
      .rdata_o (rdata)
    );
  end

  logic [USE_W-1:0]    use_eff;
  logic [RELIEF_W-1:0] q_relief;
  logic                q_found;
  logic [LEVEL_W-1:0]  q_level;

  always_comb begin
    if (levels_q == 3'd0) begin
      use_eff = USE_W'(1);
    end else if ({1'b0, levels_q} > USE_W'(LEVELS)) begin
      use_eff = USE_W'(LEVELS);
    end else begin
      use_eff = {1'b0, levels_q};
    end
  end

  always_comb begin
    q_relief = EMPTY_RELIEF;
    q_found  = 1'b0;
    q_level  = '0;
    for (int d = LEVELS - 1; d >= 0; d--) begin
      if (s1_inrange_q && (d < int'(use_eff)) && entries[d][ENTRY_W-1]) begin
        q_relief = entries[d][RELIEF_W-1:0];
        q_found  = 1'b1;
        q_level  = LEVEL_W'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && s1_result) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && s1_result) begin
      if (s1_kind_q == KIND_ADD) begin
        cell_relief_q <= '0;
        found_q       <= 1'b0;
        level_used_q  <= '0;
        out_of_map_q  <= s1_outside_q;
      end else begin
        cell_relief_q <= q_relief;
        found_q       <= q_found;
        level_used_q  <= q_level;
        out_of_map_q  <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.cell_relief = cell_relief_q;
  assign out_o.found       = found_q;
  assign out_o.level_used  = level_used_q;
  assign out_o.out_of_map  = out_of_map_q;

endmodule

`default_nettype wire

### hw/rtl/hfm_checker.sv
// Port-level checker for the multiscale hole-fill max map and its bind.
// Depends on hfm_pkg and on the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

module hfm_checker
  import hfm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [RELIEF_W-1:0] cell_relief_i,
  input wire logic                found_i,
  input wire logic [LEVEL_W-1:0]  level_used_i,
  input wire logic                out_of_map_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_relief_i) &&
      $stable(found_i) && $stable(level_used_i) && $stable(out_of_map_i))
    else $error("Result changed while stalled.");

  a_found_not_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> !out_of_map_i)
    else $error("Query result carries the outside flag.");

  a_add_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_map_i |-> (cell_relief_i == '0) && (level_used_i == '0))
    else $error("Add result carries relief or level.");

  a_empty_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i && (cell_relief_i != '0) |->
      (cell_relief_i == EMPTY_RELIEF) && (level_used_i == '0) && !out_of_map_i)
    else $error("Empty query answer is malformed.");

endmodule

bind multiscale_hole_fill_max_map hfm_checker u_hfm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .cell_relief_i (out_o.cell_relief),
  .found_i       (out_o.found),
  .level_used_i  (out_o.level_used),
  .out_of_map_i  (out_o.out_of_map)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the multiscale hole-fill max map: a directed table, then
// random phases over several map settings, checked against a max-pyramid predictor but
// for typed table rows. Depends on hfm_pkg, hfm_if and multiscale_hole_fill_max_map.
`timescale 1ns / 1ps

module tb_top;
  import hfm_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 255;
  localparam int unsigned DIR_ROWS = 25;

  localparam int unsigned PH_ROWS [PHASES] = '{256, 1, 256, 13, 64, 200};
  localparam int unsigned PH_COLS [PHASES] = '{256, 1, 1, 200, 64, 256};
  localparam int unsigned PH_LVLS [PHASES] = '{4, 1, 0, 5, 2, 3};
  localparam bit PH_CLEAR [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam logic [15:0] RELIEF_CORNERS [6] =
    '{16'h7FFF, 16'h8000, 16'hFF00, 16'h0000, 16'hFFFF, 16'h0001};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] relief;
  } hfm_item_t;

  typedef struct packed {
    logic [15:0] cell_relief;
    logic        found;
    logic [1:0]  level_used;
    logic        out_of_map;
  } hfm_result_t;

  typedef struct packed {
    hfm_item_t   it;
    logic        typed;
    hfm_result_t want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  hfm_in_if  item_if ();
  hfm_out_if res_if ();

  multiscale_hole_fill_max_map i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (item_if),
    .out_o      (res_if)
  );

  logic [ENTRY_W-1:0] relief_pyr [LEVELS][ROWS_MAX][COLS_MAX];
  logic [CFG_W-1:0]   rows_cfg = 9'd256;
  logic [CFG_W-1:0]   cols_cfg = 9'd256;
  logic [2:0]         lvls_cfg = 3'd4;

  hfm_result_t   expected_q [$];
  logic [15:0]   pts_q [$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   burst_left = 0;
  dir_row_t      dir_tab [DIR_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_pyramid();
    foreach (relief_pyr[d, r, c]) relief_pyr[d][r][c] = '0;
  endtask

  // Applies one accepted item to the predicted pyramid and works out its result.
  task automatic apply_item(input hfm_item_t it, output bit has_res, output hfm_result_t res);
    logic [ENTRY_W-1:0] e;
    int unsigned        use_lvls;
    bit                 outside;
    res = '0;
    has_res = 1'b0;
    case (it.kind)
      KIND_CLEAR: clear_pyramid();
      KIND_ADD: begin
        has_res = 1'b1;
        outside = ({1'b0, it.row} >= rows_cfg) || ({1'b0, it.col} >= cols_cfg) ||
                  (32'(it.row) >= ROWS_MAX) || (32'(it.col) >= COLS_MAX);
        if (!outside) begin
          for (int d = 0; d < LEVELS; d++) begin
            e = relief_pyr[d][it.row >> d][it.col >> d];
            if (!e[ENTRY_W-1] || $signed(it.relief) > $signed(e[15:0]))
              relief_pyr[d][it.row >> d][it.col >> d] = {1'b1, it.relief};
          end
        end
        res.out_of_map = outside;
      end
      KIND_QUERY: begin
        has_res = 1'b1;
        use_lvls = (lvls_cfg == 0) ? 1 : (lvls_cfg > LEVELS) ? LEVELS : lvls_cfg;
        res.cell_relief = EMPTY_RELIEF;
        if (32'(it.row) < ROWS_MAX && 32'(it.col) < COLS_MAX) begin
          for (int d = 0; d < use_lvls; d++) begin
            e = relief_pyr[d][it.row >> d][it.col >> d];
            if (!res.found && e[ENTRY_W-1]) begin
              res.cell_relief = e[15:0];
              res.found = 1'b1;
              res.level_used = d[1:0];
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_cnt < 100)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_result();
    hfm_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with no item pending", 1, 0);
      return;
    end
    want = expected_q.pop_front();
    if (res_if.cell_relief !== want.cell_relief)
      report_mismatch("cell_relief", res_if.cell_relief, want.cell_relief);
    if (res_if.found !== want.found)
      report_mismatch("found", res_if.found, want.found);
    if (res_if.level_used !== want.level_used)
      report_mismatch("level_used", res_if.level_used, want.level_used);
    if (res_if.out_of_map !== want.out_of_map)
      report_mismatch("out_of_map", res_if.out_of_map, want.out_of_map);
  endtask

  // The sender works in bursts; the gap before a burst may be empty.
  task automatic send_item(input hfm_item_t it, input bit typed, input hfm_result_t want);
    hfm_result_t r;
    bit          has_r;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    item_if.valid        <= 1'b1;
    item_if.kind         <= it.kind;
    item_if.cell_row     <= it.row;
    item_if.cell_col     <= it.col;
    item_if.point_relief <= it.relief;
    do @(posedge clk_i); while (!item_if.ready);
    burst_left--;
    apply_item(it, has_r, r);
    if (has_r) expected_q.insert(expected_q.size(), typed ? want : r);
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_map_config(input int unsigned rows, input int unsigned cols,
                                  input int unsigned lvls);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MAP_ROWS;
    cfg_data <= CFG_W'(rows);
    @(posedge clk_i);
    cfg_idx  <= CFG_MAP_COLS;
    cfg_data <= CFG_W'(cols);
    @(posedge clk_i);
    cfg_idx  <= CFG_LEVELS;
    cfg_data <= CFG_W'(lvls);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    rows_cfg = CFG_W'(rows);
    cols_cfg = CFG_W'(cols);
    lvls_cfg = 3'(lvls);
  endtask

  // Four in ten coordinates fall near earlier points so that the coarser levels get hits.
  task automatic pick_item(output hfm_item_t it);
    int unsigned sel;
    int unsigned k;
    logic [15:0] p;
    k = $urandom_range(0, 19);
    it.kind = (k == 0) ? KIND_NONE : (k < 10) ? KIND_ADD : KIND_QUERY;
    sel = $urandom_range(0, 9);
    if (sel < 4 && pts_q.size() != 0) begin
      p = pts_q[$urandom_range(0, pts_q.size() - 1)];
      it.row = p[15:8] + 8'($urandom_range(0, 14)) - 8'd7;
      it.col = p[7:0] + 8'($urandom_range(0, 14)) - 8'd7;
    end else if (sel < 8) begin
      it.row = 8'($urandom_range(0, int'(rows_cfg) - 1));
      it.col = 8'($urandom_range(0, int'(cols_cfg) - 1));
    end else begin
      it.row = 8'($urandom);
      it.col = 8'($urandom);
    end
    it.relief = ($urandom_range(0, 4) == 0) ? RELIEF_CORNERS[$urandom_range(0, 5)]
                                            : 16'($urandom);
    if (it.kind == KIND_ADD) begin
      pts_q.insert(pts_q.size(), {it.row, it.col});
      if (pts_q.size() > 16) void'(pts_q.pop_front());
    end
  endtask

  function automatic dir_row_t mk(input logic [1:0] kind, input int unsigned row,
                                  input int unsigned col, input logic [15:0] relief,
                                  input bit typed, input logic [15:0] cell_relief,
                                  input bit found, input int unsigned lvl, input bit oom);
    dir_row_t t;
    t.it = '{kind, 8'(row), 8'(col), relief};
    t.typed = typed;
    t.want = '{cell_relief, found, 2'(lvl), oom};
    return t;
  endfunction

  initial begin
    hfm_item_t it;
    int unsigned n;
    item_if.valid        = 1'b0;
    item_if.kind         = KIND_CLEAR;
    item_if.cell_row     = '0;
    item_if.cell_col     = '0;
    item_if.point_relief = '0;
    res_if.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_MAP_ROWS;
    cfg_data             = '0;
    rst_ni               = 1'b0;
    clear_pyramid();

    dir_tab = '{
      mk(KIND_QUERY, 0,   0,   16'h0000, 1, EMPTY_RELIEF, 0, 0, 0),
      mk(KIND_QUERY, 255, 255, 16'hFFFF, 1, EMPTY_RELIEF, 0, 0, 0),
      mk(KIND_ADD,   0,   0,   16'h7FFF, 1, 16'h0000, 0, 0, 0),
      mk(KIND_ADD,   199, 99,  16'h8000, 1, 16'h0000, 0, 0, 0),
      mk(KIND_ADD,   200, 0,   16'h1234, 1, 16'h0000, 0, 0, 1),
      mk(KIND_ADD,   0,   100, 16'h1234, 1, 16'h0000, 0, 0, 1),
      mk(KIND_ADD,   255, 255, 16'hFFFF, 1, 16'h0000, 0, 0, 1),
      mk(KIND_QUERY, 0,   0,   16'h0000, 1, 16'h7FFF, 1, 0, 0),
      mk(KIND_QUERY, 199, 99,  16'h0000, 1, 16'h8000, 1, 0, 0),
      mk(KIND_QUERY, 1,   1,   16'h0000, 1, 16'h7FFF, 1, 1, 0),
      mk(KIND_QUERY, 7,   7,   16'h0000, 1, 16'h7FFF, 1, 3, 0),
      mk(KIND_ADD,   6,   5,   16'hFF00, 1, 16'h0000, 0, 0, 0),
      mk(KIND_QUERY, 6,   5,   16'h0000, 1, 16'hFF00, 1, 0, 0),
      mk(KIND_QUERY, 4,   4,   16'h0000, 1, 16'hFF00, 1, 2, 0),
      mk(KIND_ADD,   6,   4,   16'h0100, 0, 16'h0000, 0, 0, 0),
      mk(KIND_QUERY, 7,   5,   16'h0000, 0, 16'h0000, 0, 0, 0),
      mk(KIND_ADD,   0,   1,   16'h8000, 0, 16'h0000, 0, 0, 0),
      mk(KIND_QUERY, 0,   1,   16'h0000, 0, 16'h0000, 0, 0, 0),
      mk(KIND_QUERY, 200, 0,   16'h0000, 0, 16'h0000, 0, 0, 0),
      mk(KIND_NONE,  255, 255, 16'h7FFF, 0, 16'h0000, 0, 0, 0),
      mk(KIND_ADD,   198, 98,  16'hAAAA, 0, 16'h0000, 0, 0, 0),
      mk(KIND_QUERY, 198, 99,  16'h5555, 0, 16'h0000, 0, 0, 0),
      mk(KIND_CLEAR, 255, 255, 16'hFFFF, 0, 16'h0000, 0, 0, 0),
      mk(KIND_QUERY, 0,   0,   16'h0000, 1, EMPTY_RELIEF, 0, 0, 0),
      mk(KIND_QUERY, 199, 99,  16'h0000, 1, EMPTY_RELIEF, 0, 0, 0)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_map_config(200, 100, 4);

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_map_config(PH_ROWS[p], PH_COLS[p], PH_LVLS[p]);
      pts_q.delete();
      if (PH_CLEAR[p]) begin
        it = '{KIND_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom)};
        send_item(it, 1'b0, '0);
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick_item(it);
        send_item(it, 1'b0, '0);
        n++;
        if (p == 2 && n == PHASE_ITEMS / 2) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: checks every transfer and stalls on a pattern of its own, with one
  // long hold-off part way through so that the block backs up onto its input.
  int unsigned results_seen = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic [1:0]  rx_mode = 2'd0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        check_result();
        results_seen <= results_seen + 1;
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 400) begin
        hold_done    <= 1'b1;
        hold_left    <= 500;
        res_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   <= 2'($urandom_range(0, 3));
          mode_left <= $urandom_range(16, 96);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (rx_mode)
          2'd0: res_if.ready <= 1'b1;
          2'd1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2'd2: res_if.ready <= 1'($urandom_range(0, 1));
          default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
